### rtl/core/hrss_pkg.sv
package hrss_pkg;

  localparam int SPEED_W    = 9;
  localparam int STEER_W    = 7;
  localparam int BRAKE_W    = 7;
  localparam int HOLD_W     = 12;
  localparam int PERIOD_W   = 4;
  localparam int SPD_STEP_W = 8;
  localparam int STR_STEP_W = 4;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_TIMERS = 4;

  localparam int T_UP    = 0;
  localparam int T_DOWN  = 1;
  localparam int T_LEFT  = 2;
  localparam int T_RIGHT = 3;

  localparam logic [SPEED_W-1:0] SPEED_FLOOR        = 9'd10;
  localparam logic [SPEED_W-1:0] SPEED_MAX          = 9'd511;
  localparam logic [BRAKE_W-1:0] BRAKE_ENGAGED_POS  = 7'd32;
  localparam logic [BRAKE_W-1:0] BRAKE_RELEASED_POS = 7'd109;
  localparam logic [STEER_W-1:0] STEER_CENTRE       = 7'd74;
  localparam logic [HOLD_W-1:0]  HOLD_MAX           = 12'd4095;

  localparam logic [PERIOD_W-1:0]   RST_SPEED_PERIOD = 4'd4;
  localparam logic [PERIOD_W-1:0]   RST_STEER_PERIOD = 4'd1;
  localparam logic [SPD_STEP_W-1:0] RST_SPEED_STEP   = 8'd20;
  localparam logic [SPEED_W-1:0]    RST_SPEED_LIMIT  = 9'd400;
  localparam logic [STR_STEP_W-1:0] RST_STEER_STEP   = 4'd4;
  localparam logic [STEER_W-1:0]    RST_STEER_LOW    = 7'd28;
  localparam logic [STEER_W-1:0]    RST_STEER_HIGH   = 7'd120;
  localparam logic [HOLD_W-1:0]     RST_BRAKE_HOLD   = 12'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_PERIOD = 3'd0,
    CFG_STEER_PERIOD = 3'd1,
    CFG_SPEED_STEP   = 3'd2,
    CFG_SPEED_LIMIT  = 3'd3,
    CFG_STEER_STEP   = 3'd4,
    CFG_STEER_LOW    = 3'd5,
    CFG_STEER_HIGH   = 3'd6,
    CFG_BRAKE_HOLD   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]   speed_repeat_period;
    logic [PERIOD_W-1:0]   steer_repeat_period;
    logic [SPD_STEP_W-1:0] speed_step;
    logic [SPEED_W-1:0]    speed_limit;
    logic [STR_STEP_W-1:0] steer_step;
    logic [STEER_W-1:0]    steer_low;
    logic [STEER_W-1:0]    steer_high;
    logic [HOLD_W-1:0]     brake_hold_samples;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_duty;
    logic               drive_enable;
    logic [STEER_W-1:0] steer_position;
    logic [BRAKE_W-1:0] brake_position;
  } result_t;

endpackage

### rtl/core/hrss_in_if.sv
interface hrss_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic speed_up_pressed;
  logic speed_down_pressed;
  logic brake_pressed;
  logic left_pressed;
  logic right_pressed;

  modport source (output valid, tick, speed_up_pressed, speed_down_pressed, brake_pressed,
                  left_pressed, right_pressed, input ready);
  modport sink (input valid, tick, speed_up_pressed, speed_down_pressed, brake_pressed,
                left_pressed, right_pressed, output ready);
endinterface

### rtl/core/hrss_out_if.sv
interface hrss_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] speed_duty;
  logic       drive_enable;
  logic [6:0] steer_position;
  logic [6:0] brake_position;

  modport source (output valid, speed_duty, drive_enable, steer_position, brake_position,
                  input ready);
  modport sink (input valid, speed_duty, drive_enable, steer_position, brake_position,
                output ready);
endinterface

### rtl/core/hrss_timer.sv
module hrss_timer import hrss_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                level_now,
  input  logic                level_was,
  input  logic [PERIOD_W-1:0] period_cfg,
  input  logic                tick,
  input  logic                disarm,
  output logic                fire
);

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic                phase_r, phase_nxt;
  logic [PERIOD_W-1:0] active;
  logic [PERIOD_W-1:0] count_inc;
  logic                run;
  logic                reach;

  always_comb begin
    if (level_now && !level_was) begin
      active = period_cfg;
    end else if (!level_now && level_was) begin
      active = '0;
    end else begin
      active = period_r;
    end
    run       = tick && (active != '0);
    count_inc = count_r + 1'b1;
    reach     = run && (count_inc >= active);
    fire      = reach && !phase_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    if (run) begin
      count_nxt = reach ? '0 : count_inc;
    end
    if (reach) begin
      phase_nxt = !phase_r;
    end
    period_nxt = disarm ? '0 : active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      count_r  <= '0;
      phase_r  <= 1'b0;
    end else if (en) begin
      period_r <= period_nxt;
      count_r  <= count_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

### rtl/core/hrss_motion.sv
module hrss_motion import hrss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cfg_t                  cfg,
  input  logic                  brake,
  input  logic [NUM_TIMERS-1:0] fire,
  output logic [NUM_TIMERS-1:0] disarm,
  output result_t               result_nxt
);

  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic               drive_r, drive_nxt;
  logic [STEER_W-1:0] steer_r, steer_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic               engaged_r, engaged_nxt;

  logic [SPEED_W-1:0] sp0, sp1;
  logic               drv0, drv1;
  logic [SPEED_W:0]   sp_sum;
  logic [SPEED_W-1:0] step9;
  logic [STEER_W-1:0] st1;
  logic [STEER_W:0]   st_sum;
  logic [STEER_W-1:0] st_diff;
  logic [STEER_W-1:0] sstep7;

  always_comb begin
    disarm  = '0;
    step9   = {1'b0, cfg.speed_step};
    sstep7  = {{(STEER_W-STR_STEP_W){1'b0}}, cfg.steer_step};
    sp0     = speed_r;
    drv0    = drive_r;
    hold_nxt    = hold_r;
    engaged_nxt = engaged_r;
    if (brake) begin
      if (hold_r >= cfg.brake_hold_samples) begin
        sp0         = '0;
        drv0        = 1'b0;
        engaged_nxt = 1'b1;
      end
      if (hold_r != HOLD_MAX) begin
        hold_nxt = hold_r + 1'b1;
      end
    end else begin
      hold_nxt    = '0;
      engaged_nxt = 1'b0;
    end

    sp_sum = {1'b0, sp0} + {1'b0, step9};
    sp1    = sp0;
    drv1   = drv0;
    if (fire[T_UP]) begin
      if (sp0 < cfg.speed_limit) begin
        sp1  = sp_sum[SPEED_W] ? SPEED_MAX : sp_sum[SPEED_W-1:0];
        drv1 = 1'b1;
      end else begin
        disarm[T_UP] = 1'b1;
      end
    end

    speed_nxt = sp1;
    drive_nxt = drv1;
    if (fire[T_DOWN]) begin
      if (sp1 > SPEED_FLOOR) begin
        speed_nxt = (sp1 > step9) ? sp1 - step9 : '0;
        drive_nxt = 1'b1;
      end else begin
        drive_nxt      = 1'b0;
        disarm[T_DOWN] = 1'b1;
      end
    end

    st_sum = {1'b0, steer_r} + {1'b0, sstep7};
    st1    = steer_r;
    if (fire[T_LEFT]) begin
      if (steer_r < cfg.steer_high) begin
        st1 = (st_sum > {1'b0, cfg.steer_high}) ? cfg.steer_high : st_sum[STEER_W-1:0];
      end else begin
        disarm[T_LEFT] = 1'b1;
      end
    end

    st_diff   = (st1 > sstep7) ? st1 - sstep7 : '0;
    steer_nxt = st1;
    if (fire[T_RIGHT]) begin
      if (st1 > cfg.steer_low) begin
        steer_nxt = (st_diff < cfg.steer_low) ? cfg.steer_low : st_diff;
      end else begin
        disarm[T_RIGHT] = 1'b1;
      end
    end

    result_nxt.speed_duty     = speed_nxt;
    result_nxt.drive_enable   = drive_nxt;
    result_nxt.steer_position = steer_nxt;
    result_nxt.brake_position = engaged_nxt ? BRAKE_ENGAGED_POS : BRAKE_RELEASED_POS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      drive_r   <= 1'b0;
      steer_r   <= STEER_CENTRE;
      hold_r    <= '0;
      engaged_r <= 1'b0;
    end else if (en) begin
      speed_r   <= speed_nxt;
      drive_r   <= drive_nxt;
      steer_r   <= steer_nxt;
      hold_r    <= hold_nxt;
      engaged_r <= engaged_nxt;
    end
  end

endmodule

### rtl/core/hold_repeat_speed_steer_ramp.sv
// Hold-to-repeat speed and steer ramp. Each accepted request is one sample of the five
// button levels and a tick; its result appears in the output register in the cycle
// after acceptance. One request is taken every cycle while the output is not stalled:
// the whole update of the repeat timers, speed, steer and brake state is combinational,
// and a new request is accepted whenever the output register is empty or its result
// is taken in the same cycle. The user must write configuration registers through the
// cfg port only while the block is idle (not enforced); they act on the next request.
module hold_repeat_speed_steer_ramp import hrss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hrss_in_if.sink               in_req,
  hrss_out_if.source            out_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg_r;
  logic [NUM_TIMERS-1:0] levels;
  logic [NUM_TIMERS-1:0] prev_levels_r;
  logic [NUM_TIMERS-1:0] fire;
  logic [NUM_TIMERS-1:0] disarm;
  logic                  accept;
  logic                  out_valid_r;
  result_t               result_r, result_nxt;

  assign in_req.ready = !out_valid_r || out_req.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign levels       = {in_req.right_pressed, in_req.left_pressed,
                         in_req.speed_down_pressed, in_req.speed_up_pressed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_repeat_period <= RST_SPEED_PERIOD;
      cfg_r.steer_repeat_period <= RST_STEER_PERIOD;
      cfg_r.speed_step          <= RST_SPEED_STEP;
      cfg_r.speed_limit         <= RST_SPEED_LIMIT;
      cfg_r.steer_step          <= RST_STEER_STEP;
      cfg_r.steer_low           <= RST_STEER_LOW;
      cfg_r.steer_high          <= RST_STEER_HIGH;
      cfg_r.brake_hold_samples  <= RST_BRAKE_HOLD;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SPEED_PERIOD: cfg_r.speed_repeat_period <= cfg_wdata[PERIOD_W-1:0];
        CFG_STEER_PERIOD: cfg_r.steer_repeat_period <= cfg_wdata[PERIOD_W-1:0];
        CFG_SPEED_STEP:   cfg_r.speed_step          <= cfg_wdata[SPD_STEP_W-1:0];
        CFG_SPEED_LIMIT:  cfg_r.speed_limit         <= cfg_wdata[SPEED_W-1:0];
        CFG_STEER_STEP:   cfg_r.steer_step          <= cfg_wdata[STR_STEP_W-1:0];
        CFG_STEER_LOW:    cfg_r.steer_low           <= cfg_wdata[STEER_W-1:0];
        CFG_STEER_HIGH:   cfg_r.steer_high          <= cfg_wdata[STEER_W-1:0];
        CFG_BRAKE_HOLD:   cfg_r.brake_hold_samples  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '0;
    end else if (accept) begin
      prev_levels_r <= levels;
    end
  end

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    hrss_timer u_timer (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (accept),
      .level_now  (levels[t]),
      .level_was  (prev_levels_r[t]),
      .period_cfg ((t < 2) ? cfg_r.speed_repeat_period : cfg_r.steer_repeat_period),
      .tick       (in_req.tick),
      .disarm     (disarm[t]),
      .fire       (fire[t])
    );
  end

  hrss_motion u_motion (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (accept),
    .cfg        (cfg_r),
    .brake      (in_req.brake_pressed),
    .fire       (fire),
    .disarm     (disarm),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_req.valid          = out_valid_r;
  assign out_req.speed_duty     = result_r.speed_duty;
  assign out_req.drive_enable   = result_r.drive_enable;
  assign out_req.steer_position = result_r.steer_position;
  assign out_req.brake_position = result_r.brake_position;

endmodule

### rtl/core/hrss_checker.sv
module hrss_checker import hrss_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SPEED_W-1:0] speed_duty,
  input logic [BRAKE_W-1:0] brake_position
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_brake_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (brake_position == BRAKE_ENGAGED_POS ||
                   brake_position == BRAKE_RELEASED_POS))
    else $error("brake position is neither engaged nor released");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(speed_duty) && $stable(brake_position))
    else $error("stalled result changed");

endmodule

bind hold_repeat_speed_steer_ramp hrss_checker u_hrss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_req.valid),
  .out_ready      (out_req.ready),
  .speed_duty     (out_req.speed_duty),
  .brake_position (out_req.brake_position)
);
